/* sv/sound_file_player_regs_unit_defines.svh */
// ----------------------------------------------------------------------------
// Sound file player register unit: assertion macros
// Shared concurrent-assertion shorthands, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SOUND_FILE_PLAYER_REGS_UNIT_DEFINES_SVH
`define SOUND_FILE_PLAYER_REGS_UNIT_DEFINES_SVH

// same-cycle implication
`define SFPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sfpr_pkg.sv */
// ----------------------------------------------------------------------------
// Sound file player register package
// Command codes, configuration indexes, address map, register offsets, status codes and the boot program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfpr_pkg;

	// item commands
	localparam logic [2:0] CMD_REG_READ   = 3'd0;
	localparam logic [2:0] CMD_REG_WRITE  = 3'd1;
	localparam logic [2:0] CMD_VEC_READ   = 3'd2;
	localparam logic [2:0] CMD_TICK       = 3'd3;
	localparam logic [2:0] CMD_START      = 3'd4;
	localparam logic [2:0] CMD_STOP       = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_INIT_ADDR  = 3'd0;
	localparam logic [2:0] CFG_PLAY_ADDR  = 3'd1;
	localparam logic [2:0] CFG_NTSC_PER   = 3'd2;
	localparam logic [2:0] CFG_PAL_PER    = 3'd3;
	localparam logic [2:0] CFG_BANKS      = 3'd4;
	localparam logic [2:0] CFG_SONG       = 3'd5;
	localparam logic [2:0] CFG_VIDEO      = 3'd6;
	localparam logic [2:0] CFG_CHIPS      = 3'd7;

	// interrupt status codes
	localparam logic [7:0] ST_IDLE        = 8'hFF;
	localparam logic [7:0] ST_INIT        = 8'h00;
	localparam logic [7:0] ST_STOP        = 8'h01;
	localparam logic [7:0] ST_PLAY        = 8'h02;

	// address map
	localparam logic [11:0] ROM_BASE      = 12'hF00;
	localparam logic [11:0] REG_BASE      = 12'hE00;
	localparam logic [11:0] VEC_BASE      = 12'hFFC;
	localparam logic [7:0]  UNMAPPED      = 8'hFF;
	localparam logic [7:0]  CHIP_MASK     = 8'h3F;

	// register offsets within the page
	localparam logic [7:0] OFS_INIT_LO    = 8'h00;
	localparam logic [7:0] OFS_INIT_HI    = 8'h01;
	localparam logic [7:0] OFS_PLAY_LO    = 8'h02;
	localparam logic [7:0] OFS_PLAY_HI    = 8'h03;
	localparam logic [7:0] OFS_NTSC_LO    = 8'h04;
	localparam logic [7:0] OFS_PAL_LO     = 8'h05;
	localparam logic [7:0] OFS_NTSC_HI    = 8'h06;
	localparam logic [7:0] OFS_PAL_HI     = 8'h07;
	localparam logic [7:0] OFS_BANK_FIRST = 8'h08;
	localparam logic [7:0] OFS_BANK_LAST  = 8'h0F;
	localparam logic [7:0] OFS_SONG       = 8'h10;
	localparam logic [7:0] OFS_VIDEO      = 8'h11;
	localparam logic [7:0] OFS_STATUS     = 8'h12;
	localparam logic [7:0] OFS_CHIPS      = 8'h13;
	// write side
	localparam logic [7:0] OFS_LATCH_LO   = 8'h10;
	localparam logic [7:0] OFS_LATCH_HI   = 8'h11;
	localparam logic [7:0] OFS_ARM        = 8'h12;
	localparam logic [7:0] OFS_RELOAD     = 8'h13;

	localparam logic [7:0] BOOT_ROM [256] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h78,8'hD8,8'hA2,8'hFF,8'h9A,8'h8E,
		8'h17,8'h40,8'hE8,8'h8E,8'h15,8'h40,8'h8E,8'h00,
		8'h20,8'h8E,8'h01,8'h20,8'h8E,8'h12,8'h3E,8'h58,
		8'h4C,8'h20,8'h3F,8'hAE,8'h12,8'h3E,8'hF0,8'h56,
		8'hCA,8'hF0,8'h04,8'h20,8'hF9,8'h3F,8'h40,8'h8E,
		8'h12,8'h3E,8'h8E,8'h15,8'h40,8'hAD,8'h13,8'h3E,
		8'h4A,8'h90,8'h09,8'h8E,8'h02,8'h90,8'h8E,8'h02,
		8'hA0,8'h8E,8'h02,8'hB0,8'h4A,8'h90,8'h0D,8'hA0,
		8'h20,8'h8C,8'h10,8'h90,8'h8E,8'h30,8'h90,8'hC8,
		8'hC0,8'h26,8'hD0,8'hF5,8'h4A,8'h90,8'h0B,8'hA0,
		8'h80,8'h8C,8'h83,8'h40,8'h8C,8'h87,8'h40,8'h8C,
		8'h89,8'h40,8'h4A,8'h90,8'h03,8'h8E,8'h15,8'h50,
		8'h4A,8'h90,8'h07,8'h88,8'h8E,8'h00,8'hF8,8'h8E,
		8'h00,8'h48,8'h4A,8'h90,8'h08,8'hA0,8'h07,8'h8C,
		8'h00,8'hC0,8'h8C,8'h00,8'hE0,8'h40,8'hA2,8'hFF,
		8'h9A,8'h8E,8'hF7,8'h5F,8'hCA,8'h8E,8'hF6,8'h5F,
		8'hA9,8'h00,8'hA2,8'h7F,8'h85,8'h00,8'h86,8'h01,
		8'hA8,8'hA2,8'h27,8'h91,8'h00,8'hC8,8'hD0,8'hFB,
		8'hCA,8'h30,8'h0A,8'hC6,8'h01,8'hE0,8'h07,8'hD0,
		8'hF2,8'h86,8'h01,8'hF0,8'hEE,8'hA2,8'h14,8'hCA,
		8'h9D,8'h00,8'h40,8'hD0,8'hFA,8'hA2,8'h07,8'hBD,
		8'h08,8'h3E,8'h9D,8'hF8,8'h5F,8'hCA,8'h10,8'hF7,
		8'hA0,8'h0F,8'h8C,8'h15,8'h40,8'hAD,8'h13,8'h3E,
		8'h29,8'h04,8'hF0,8'h10,8'hAD,8'h0E,8'h3E,8'hF0,
		8'h03,8'h8D,8'hF6,8'h5F,8'hAD,8'h0F,8'h3E,8'hF0,
		8'h03,8'h8D,8'hF7,8'h5F,8'hAE,8'h11,8'h3E,8'hBD,
		8'h04,8'h3E,8'h8D,8'h10,8'h3E,8'hBD,8'h06,8'h3E,
		8'h8D,8'h11,8'h3E,8'h8C,8'h12,8'h3E,8'hAD,8'h12,
		8'h3E,8'h58,8'hAD,8'h10,8'h3E,8'h20,8'hF6,8'h3F,
		8'h8D,8'h13,8'h3E,8'h4C,8'h20,8'h3F,8'h6C,8'h00,
		8'h3E,8'h6C,8'h02,8'h3E,8'h0A,8'h3F,8'h23,8'h3F
	};

endpackage

/* sv/sound_file_player_regs_unit.sv */
// ----------------------------------------------------------------------------
// Sound file player register unit
// Register block of a music-file player mapper: tune parameters, play-rate
// counter with watchdog, interrupt status and boot program reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sound_file_player_regs_unit_defines.svh"

// One bus access, tick or start/stop command is taken per clock while ready
// and gives exactly one result beat, registered, in the cycle after the input
// beat. Input ready drops only while a result waits and the output side is
// stalled. The path between the state registers and the result register is one
// pass of decode, the 32-bit counter decrement and the read mux. Configuration
// writes are always ready and take effect at once; write them while idle.
module sound_file_player_regs_unit (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        read_handled,
	output logic        irq_active,
	output logic        watchdog_alarm,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// configuration registers
	logic [15:0] init_addr_q;
	logic [15:0] play_addr_q;
	logic [15:0] ntsc_per_q;
	logic [15:0] pal_per_q;
	logic [63:0] banks_q;
	logic [7:0]  song_q;
	logic        video_q;
	logic [7:0]  chips_q;

	// play state
	logic [7:0]  status_q;
	logic [31:0] counter_q;
	logic [15:0] latch_q;
	logic        enable_q;
	logic        armed_q;

	// result register
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic        handled_q;
	logic        irq_active_q;
	logic        alarm_q;

	logic        accept;
	logic [7:0]  sel;
	logic [7:0]  reg_byte;
	logic [7:0]  rd_d;
	logic        handled_d;
	logic        alarm_d;
	logic [7:0]  status_d;
	logic [31:0] counter_d;
	logic [31:0] counter_dec;
	logic [15:0] latch_d;
	logic        enable_d;
	logic        armed_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign sel       = address[7:0];

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign read_handled   = handled_q;
	assign irq_active     = irq_active_q;
	assign watchdog_alarm = alarm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_addr_q <= '0;
			play_addr_q <= '0;
			ntsc_per_q  <= '0;
			pal_per_q   <= '0;
			banks_q     <= '0;
			song_q      <= '0;
			video_q     <= 1'b0;
			chips_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfpr_pkg::CFG_INIT_ADDR: init_addr_q <= cfg_data[15:0];
				sfpr_pkg::CFG_PLAY_ADDR: play_addr_q <= cfg_data[15:0];
				sfpr_pkg::CFG_NTSC_PER:  ntsc_per_q  <= cfg_data[15:0];
				sfpr_pkg::CFG_PAL_PER:   pal_per_q   <= cfg_data[15:0];
				sfpr_pkg::CFG_BANKS:     banks_q     <= cfg_data;
				sfpr_pkg::CFG_SONG:      song_q      <= cfg_data[7:0];
				sfpr_pkg::CFG_VIDEO:     video_q     <= cfg_data[0];
				sfpr_pkg::CFG_CHIPS:     chips_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// register page byte (offsets 0xE00..0xEFF)
	always_comb begin
		reg_byte = sfpr_pkg::UNMAPPED;
		if (sel >= sfpr_pkg::OFS_BANK_FIRST && sel <= sfpr_pkg::OFS_BANK_LAST) begin
			reg_byte = banks_q[{sel[2:0], 3'b000} +: 8];
		end else begin
			unique case (sel)
				sfpr_pkg::OFS_INIT_LO: reg_byte = init_addr_q[7:0];
				sfpr_pkg::OFS_INIT_HI: reg_byte = init_addr_q[15:8];
				sfpr_pkg::OFS_PLAY_LO: reg_byte = play_addr_q[7:0];
				sfpr_pkg::OFS_PLAY_HI: reg_byte = play_addr_q[15:8];
				sfpr_pkg::OFS_NTSC_LO: reg_byte = ntsc_per_q[7:0];
				sfpr_pkg::OFS_PAL_LO:  reg_byte = pal_per_q[7:0];
				sfpr_pkg::OFS_NTSC_HI: reg_byte = ntsc_per_q[15:8];
				sfpr_pkg::OFS_PAL_HI:  reg_byte = pal_per_q[15:8];
				sfpr_pkg::OFS_SONG:    reg_byte = song_q;
				sfpr_pkg::OFS_VIDEO:   reg_byte = {7'd0, video_q};
				sfpr_pkg::OFS_STATUS:  reg_byte = status_q;
				sfpr_pkg::OFS_CHIPS:   reg_byte = chips_q & sfpr_pkg::CHIP_MASK;
				default:               reg_byte = sfpr_pkg::UNMAPPED;
			endcase
		end
	end

	assign counter_dec = counter_q - 32'd1;

	always_comb begin
		rd_d      = 8'd0;
		handled_d = 1'b0;
		alarm_d   = 1'b0;
		status_d  = status_q;
		counter_d = counter_q;
		latch_d   = latch_q;
		enable_d  = enable_q;
		armed_d   = armed_q;
		unique case (command)
			sfpr_pkg::CMD_REG_READ: begin
				if (address >= sfpr_pkg::ROM_BASE) begin
					rd_d = sfpr_pkg::BOOT_ROM[sel];
				end else if (address < sfpr_pkg::REG_BASE) begin
					rd_d = sfpr_pkg::UNMAPPED;
				end else begin
					rd_d = reg_byte;
					// status read acknowledges the interrupt
					if (sel == sfpr_pkg::OFS_STATUS) begin
						status_d = sfpr_pkg::ST_IDLE;
					end
				end
			end
			sfpr_pkg::CMD_REG_WRITE: begin
				unique case (sel)
					sfpr_pkg::OFS_LATCH_LO: latch_d = {latch_q[15:8], write_data};
					sfpr_pkg::OFS_LATCH_HI: latch_d = {write_data, latch_q[7:0]};
					sfpr_pkg::OFS_ARM: begin
						// latch * 5 as shift-and-add
						counter_d = {14'd0, latch_q, 2'b00} + {16'd0, latch_q};
						armed_d   = 1'b1;
						enable_d  = (write_data != 8'd0);
					end
					sfpr_pkg::OFS_RELOAD: begin
						counter_d = {16'd0, latch_q};
						armed_d   = 1'b0;
					end
					default: ;
				endcase
			end
			sfpr_pkg::CMD_VEC_READ: begin
				if (address >= sfpr_pkg::VEC_BASE && status_q != sfpr_pkg::ST_IDLE) begin
					rd_d      = sfpr_pkg::BOOT_ROM[sel];
					handled_d = 1'b1;
				end
			end
			sfpr_pkg::CMD_TICK: begin
				if (enable_q) begin
					if (counter_dec == 32'd0) begin
						alarm_d   = armed_q;
						counter_d = {16'd0, latch_q};
						status_d  = sfpr_pkg::ST_PLAY;
					end else begin
						counter_d = counter_dec;
					end
				end
			end
			sfpr_pkg::CMD_START: status_d = sfpr_pkg::ST_INIT;
			sfpr_pkg::CMD_STOP:  status_d = sfpr_pkg::ST_STOP;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= sfpr_pkg::ST_INIT;
			counter_q   <= '0;
			latch_q     <= '0;
			enable_q    <= 1'b0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				status_q  <= status_d;
				counter_q <= counter_d;
				latch_q   <= latch_d;
				enable_q  <= enable_d;
				armed_q   <= armed_d;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q  <= rd_d;
			handled_q    <= handled_d;
			irq_active_q <= (status_d != sfpr_pkg::ST_IDLE);
			alarm_q      <= alarm_d;
		end
	end

	`SFPR_ASSERT_NEXT(a_beat_gives_result, clk, arst_n, accept, out_valid,
		"accepted beat produced no result")
	`SFPR_ASSERT_SAME(a_alarm_sets_irq, clk, arst_n, out_valid && watchdog_alarm,
		irq_active, "watchdog alarm without pending interrupt")
	`SFPR_ASSERT_SAME(a_handled_needs_irq, clk, arst_n, out_valid && read_handled,
		irq_active, "vector read handled while status idle")
	`SFPR_ASSERT_SAME(a_status_never_other, clk, arst_n, 1'b1,
		status_q == sfpr_pkg::ST_IDLE || status_q == sfpr_pkg::ST_INIT ||
		status_q == sfpr_pkg::ST_STOP || status_q == sfpr_pkg::ST_PLAY,
		"interrupt status holds an unknown code")

endmodule

/* tb/tb_sound_file_player_regs_unit.sv */
// ----------------------------------------------------------------------------
// Sound file player register unit testbench
// Drives bus accesses, ticks and start/stop commands through the item channel
// and writes the tune parameters through the configuration channel while the
// block is idle. A scoreboard predicts every result beat from its own copy of
// the registers, the play counter and the interrupt status, then compares the
// result beats in order. Stimulus has a directed part, then play sequences
// with random content: latch load, arm or reload, tick runs. Random noise
// accesses are mixed in. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sound_file_player_regs_unit;

	localparam int CYCLE_LIMIT = 200000;
	// commands the block decodes as no-ops
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [2:0] CFG_ORDER [8] = '{sfpr_pkg::CFG_INIT_ADDR,
		sfpr_pkg::CFG_PLAY_ADDR, sfpr_pkg::CFG_NTSC_PER, sfpr_pkg::CFG_PAL_PER,
		sfpr_pkg::CFG_BANKS, sfpr_pkg::CFG_SONG, sfpr_pkg::CFG_VIDEO,
		sfpr_pkg::CFG_CHIPS};

	typedef enum {FILL_ZEROS, FILL_ONES, FILL_RANDOM} cfg_fill_t;

	typedef struct {
		logic [7:0] rd;
		logic       handled;
		logic       active;
		logic       alarm;
	} player_result_t;

	class player_regs_scoreboard;
		logic [15:0] init_addr, play_addr, ntsc_per, pal_per;
		logic [63:0] banks;
		logic [7:0]  song, chips;
		logic        video;
		logic [7:0]  status;
		logic [31:0] counter;
		logic [15:0] latch;
		logic        enable, armed;
		player_result_t expected_beats[$];
		int errors;

		function new();
			init_addr = '0;
			play_addr = '0;
			ntsc_per = '0;
			pal_per = '0;
			banks = '0;
			song = '0;
			chips = '0;
			video = 1'b0;
			status = sfpr_pkg::ST_INIT;
			counter = '0;
			latch = '0;
			enable = 1'b0;
			armed = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
			sfpr_pkg::CFG_INIT_ADDR: init_addr = val[15:0];
			sfpr_pkg::CFG_PLAY_ADDR: play_addr = val[15:0];
			sfpr_pkg::CFG_NTSC_PER:  ntsc_per = val[15:0];
			sfpr_pkg::CFG_PAL_PER:   pal_per = val[15:0];
			sfpr_pkg::CFG_BANKS:     banks = val;
			sfpr_pkg::CFG_SONG:      song = val[7:0];
			sfpr_pkg::CFG_VIDEO:     video = val[0];
			sfpr_pkg::CFG_CHIPS:     chips = val[7:0];
			default: ;
			endcase
		endfunction

		function void note_access(logic [2:0] cmd, logic [11:0] addr, logic [7:0] data);
			player_result_t r;
			logic [7:0] sel;
			sel = addr[7:0];
			r.rd = '0;
			r.handled = 1'b0;
			r.alarm = 1'b0;
			case (cmd)
			sfpr_pkg::CMD_REG_READ: begin
				if (addr >= sfpr_pkg::ROM_BASE)
					r.rd = sfpr_pkg::BOOT_ROM[sel];
				else if (addr < sfpr_pkg::REG_BASE)
					r.rd = sfpr_pkg::UNMAPPED;
				else if (sel >= sfpr_pkg::OFS_BANK_FIRST && sel <= sfpr_pkg::OFS_BANK_LAST)
					r.rd = banks[sel[2:0] * 8 +: 8];
				else
					case (sel)
					sfpr_pkg::OFS_INIT_LO: r.rd = init_addr[7:0];
					sfpr_pkg::OFS_INIT_HI: r.rd = init_addr[15:8];
					sfpr_pkg::OFS_PLAY_LO: r.rd = play_addr[7:0];
					sfpr_pkg::OFS_PLAY_HI: r.rd = play_addr[15:8];
					sfpr_pkg::OFS_NTSC_LO: r.rd = ntsc_per[7:0];
					sfpr_pkg::OFS_PAL_LO:  r.rd = pal_per[7:0];
					sfpr_pkg::OFS_NTSC_HI: r.rd = ntsc_per[15:8];
					sfpr_pkg::OFS_PAL_HI:  r.rd = pal_per[15:8];
					sfpr_pkg::OFS_SONG:    r.rd = song;
					sfpr_pkg::OFS_VIDEO:   r.rd = {7'b0, video};
					sfpr_pkg::OFS_STATUS: begin
						// read-to-clear
						r.rd = status;
						status = sfpr_pkg::ST_IDLE;
					end
					sfpr_pkg::OFS_CHIPS:   r.rd = chips & sfpr_pkg::CHIP_MASK;
					default:               r.rd = sfpr_pkg::UNMAPPED;
					endcase
			end
			sfpr_pkg::CMD_REG_WRITE: begin
				case (sel)
				sfpr_pkg::OFS_LATCH_LO: latch[7:0] = data;
				sfpr_pkg::OFS_LATCH_HI: latch[15:8] = data;
				sfpr_pkg::OFS_ARM: begin
					counter = {16'h0, latch} * 32'd5;
					armed = 1'b1;
					enable = (data != 8'h00);
				end
				sfpr_pkg::OFS_RELOAD: begin
					counter = {16'h0, latch};
					armed = 1'b0;
				end
				default: ;
				endcase
			end
			sfpr_pkg::CMD_VEC_READ: begin
				if (addr >= sfpr_pkg::VEC_BASE && status != sfpr_pkg::ST_IDLE) begin
					r.rd = sfpr_pkg::BOOT_ROM[sel];
					r.handled = 1'b1;
				end
			end
			sfpr_pkg::CMD_TICK: begin
				if (enable) begin
					// a zero counter wraps instead of expiring
					counter = counter - 32'd1;
					if (counter == 32'd0) begin
						r.alarm = armed;
						counter = {16'h0, latch};
						status = sfpr_pkg::ST_PLAY;
					end
				end
			end
			sfpr_pkg::CMD_START: status = sfpr_pkg::ST_INIT;
			sfpr_pkg::CMD_STOP:  status = sfpr_pkg::ST_STOP;
			default: ;
			endcase
			r.active = (status != sfpr_pkg::ST_IDLE);
			expected_beats.push_back(r);
		endfunction

		function void check_result(logic [7:0] rd, logic handled, logic active, logic alarm);
			player_result_t e;
			if (expected_beats.size() == 0) begin
				$error("result beat with no pending expectation");
				errors++;
				return;
			end
			e = expected_beats.pop_front();
			if (rd !== e.rd) begin
				$error("read_data: expected %h, got %h", e.rd, rd);
				errors++;
			end
			if (handled !== e.handled) begin
				$error("read_handled: expected %b, got %b", e.handled, handled);
				errors++;
			end
			if (active !== e.active) begin
				$error("irq_active: expected %b, got %b", e.active, active);
				errors++;
			end
			if (alarm !== e.alarm) begin
				$error("watchdog_alarm: expected %b, got %b", e.alarm, alarm);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  command;
	logic [11:0] address;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  read_data;
	logic        read_handled;
	logic        irq_active;
	logic        watchdog_alarm;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	player_regs_scoreboard sb;
	bit steady_flow;
	int items_sent;
	int cycle_count;

	sound_file_player_regs_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.address(address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.read_handled(read_handled),
		.irq_active(irq_active),
		.watchdog_alarm(watchdog_alarm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// result beat is checked before the same-edge input beat is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(read_data, read_handled, irq_active, watchdog_alarm);
			if (in_valid && in_ready)
				sb.note_access(command, address, write_data);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	always @(negedge clk) begin
		out_ready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 9);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL sound_file_player_regs_unit");
			$finish;
		end
	end

	task automatic send_item(input logic [2:0] cmd, input logic [11:0] addr,
		input logic [7:0] data);
		int gap;
		if (!steady_flow && $urandom_range(0, 99) < 5) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		address <= addr;
		write_data <= data;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// register write at a random address page; only the low byte selects
	task automatic send_write(input logic [7:0] sel, input logic [7:0] data);
		logic [3:0] page;
		page = 4'($urandom_range(0, 15));
		send_item(sfpr_pkg::CMD_REG_WRITE, {page, sel}, data);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.expected_beats.size() != 0);
	endtask

	task automatic load_config(input cfg_fill_t fill);
		logic [63:0] val;
		foreach (CFG_ORDER[i]) begin
			case (fill)
			FILL_ZEROS: val = '0;
			FILL_ONES:  val = '1;
			default:    val = {$urandom, $urandom};
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= CFG_ORDER[i];
			cfg_data <= val;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic play_sequence();
		logic [7:0] lo, hi;
		int ticks;
		lo = 8'($urandom_range(0, 12));
		hi = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'h00;
		send_write(sfpr_pkg::OFS_LATCH_LO, lo);
		send_write(sfpr_pkg::OFS_LATCH_HI, hi);
		if ($urandom_range(0, 99) < 70)
			send_write(sfpr_pkg::OFS_ARM,
				($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
		else
			send_write(sfpr_pkg::OFS_RELOAD, 8'($urandom));
		ticks = $urandom_range(1, lo * 5 + 8);
		repeat (ticks) begin
			if ($urandom_range(0, 99) < 15)
				case ($urandom_range(0, 5))
				0: send_item(sfpr_pkg::CMD_REG_READ,
					sfpr_pkg::REG_BASE | {4'h0, sfpr_pkg::OFS_STATUS}, 8'($urandom));
				1: send_item(sfpr_pkg::CMD_VEC_READ,
					sfpr_pkg::VEC_BASE - 12'd4 + 12'($urandom_range(0, 7)),
					8'($urandom));
				2: send_item(sfpr_pkg::CMD_START, 12'($urandom), 8'($urandom));
				3: send_item(sfpr_pkg::CMD_STOP, 12'($urandom), 8'($urandom));
				4: send_item(sfpr_pkg::CMD_REG_READ,
					sfpr_pkg::REG_BASE | 12'($urandom_range(0, 31)), 8'($urandom));
				default: send_item(sfpr_pkg::CMD_REG_READ, 12'($urandom), 8'($urandom));
				endcase
			else
				send_item(sfpr_pkg::CMD_TICK, 12'($urandom), 8'($urandom));
		end
	endtask

	task automatic noise_burst();
		logic [11:0] addr;
		int n;
		n = $urandom_range(1, 10);
		repeat (n) begin
			case ($urandom_range(0, 3))
			0: addr = 12'($urandom);
			1: addr = sfpr_pkg::REG_BASE | 12'($urandom_range(0, 31));
			2: addr = sfpr_pkg::ROM_BASE | 12'($urandom_range(0, 255));
			default: addr = {4'($urandom),
				sfpr_pkg::OFS_LATCH_LO + 8'($urandom_range(0, 3))};
			endcase
			send_item(3'($urandom), addr, 8'($urandom));
		end
	endtask

	task automatic random_items(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 65)
				play_sequence();
			else
				noise_burst();
			// hold the sender until everything outstanding has come back
			if ($urandom_range(0, 99) < 3)
				wait_drained();
		end
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = sfpr_pkg::CMD_REG_READ;
		address = '0;
		write_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = sfpr_pkg::CFG_INIT_ADDR;
		cfg_data = '0;
		steady_flow = 1'b0;
		items_sent = 0;
		cycle_count = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: all-ones config, vectors, read map, status, counter corners
		load_config(FILL_ONES);
		send_item(sfpr_pkg::CMD_VEC_READ, sfpr_pkg::VEC_BASE, 8'h00);
		send_item(sfpr_pkg::CMD_VEC_READ, 12'hFFF, 8'hFF);
		send_item(sfpr_pkg::CMD_VEC_READ, sfpr_pkg::VEC_BASE - 12'd1, 8'h00);
		send_item(sfpr_pkg::CMD_REG_READ,
			sfpr_pkg::REG_BASE | {4'h0, sfpr_pkg::OFS_INIT_LO}, 8'h00);
		send_item(sfpr_pkg::CMD_REG_READ,
			sfpr_pkg::REG_BASE | {4'h0, sfpr_pkg::OFS_BANK_LAST}, 8'h00);
		send_item(sfpr_pkg::CMD_REG_READ,
			sfpr_pkg::REG_BASE | {4'h0, sfpr_pkg::OFS_CHIPS}, 8'h00);
		send_item(sfpr_pkg::CMD_REG_READ,
			sfpr_pkg::REG_BASE | {4'h0, sfpr_pkg::OFS_CHIPS + 8'd1}, 8'h00);
		send_item(sfpr_pkg::CMD_REG_READ, sfpr_pkg::REG_BASE - 12'd1, 8'h00);
		send_item(sfpr_pkg::CMD_REG_READ, sfpr_pkg::ROM_BASE, 8'h00);
		send_item(sfpr_pkg::CMD_REG_READ,
			sfpr_pkg::REG_BASE | {4'h0, sfpr_pkg::OFS_STATUS}, 8'h00);
		send_item(sfpr_pkg::CMD_VEC_READ, sfpr_pkg::VEC_BASE, 8'h00);
		send_item(sfpr_pkg::CMD_START, 12'h000, 8'h00);
		send_item(sfpr_pkg::CMD_STOP, 12'hFFF, 8'hFF);
		send_write(sfpr_pkg::OFS_LATCH_LO, 8'h01);
		send_write(sfpr_pkg::OFS_ARM, 8'h80);
		repeat (5) send_item(sfpr_pkg::CMD_TICK, 12'h000, 8'h00);
		send_write(sfpr_pkg::OFS_RELOAD, 8'h00);
		send_item(sfpr_pkg::CMD_TICK, 12'h000, 8'h00);
		send_write(sfpr_pkg::OFS_LATCH_LO, 8'h00);
		send_write(sfpr_pkg::OFS_RELOAD, 8'h00);
		send_item(sfpr_pkg::CMD_TICK, 12'h000, 8'h00);
		send_write(sfpr_pkg::OFS_ARM, 8'h00);
		send_item(sfpr_pkg::CMD_TICK, 12'h000, 8'h00);
		send_item(CMD_SPARE_LO, 12'hFFC, 8'hFF);
		send_item(CMD_SPARE_HI, 12'hE12, 8'h01);

		wait_drained();
		load_config(FILL_RANDOM);
		random_items(600);

		wait_drained();
		load_config(FILL_ZEROS);
		steady_flow = 1'b1;
		random_items(300);
		steady_flow = 1'b0;

		wait_drained();
		load_config(FILL_RANDOM);
		random_items(900);

		wait_drained();
		repeat (4) @(negedge clk);
		if (sb.errors == 0)
			$display("PASS sound_file_player_regs_unit");
		else
			$display("FAIL sound_file_player_regs_unit");
		$finish;
	end

endmodule

/* sound_file_player_regs_unit.f */
+incdir+sv
sv/sfpr_pkg.sv
sv/sound_file_player_regs_unit.sv
tb/tb_sound_file_player_regs_unit.sv
